/* rtl/core/i2cm_pkg.sv */
`default_nettype none
package i2cm_pkg;
    localparam logic [6:0] DEV_ADDR_RESET = 7'd115;
    localparam logic [7:0] HALF_PERIOD_RESET = 8'd4;
    localparam logic [7:0] ACK_LIMIT_RESET = 8'd250;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] CFG_DEV = 2'd0;
    localparam logic [1:0] CFG_HALF = 2'd1;
    localparam logic [1:0] CFG_ACK = 2'd2;

    localparam logic [2:0] MODE_TICK = 3'd0;
    localparam logic [2:0] MODE_WRITE = 3'd1;
    localparam logic [2:0] MODE_READ = 3'd2;
    localparam logic [2:0] MODE_BURST = 3'd3;
    localparam logic [2:0] MODE_WAKE = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_ADDR_NACK = 2'd1;
    localparam logic [1:0] ST_LATE_NACK = 2'd2;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] read_count;
        logic       sda_in;
    } tick_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_enable;
        logic       busy_res;
        logic       byte_valid;
        logic [7:0] byte_data;
        logic       byte_last;
        logic       done_res;
        logic [1:0] status;
    } result_t;
endpackage
`default_nettype wire

/* rtl/core/i2cm_front.sv */
`default_nettype none
module i2cm_front
    import i2cm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire tick_t in_item,
    output logic       q_valid,
    input  wire logic  q_ready,
    output tick_t      q_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    tick_t mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0] cnt_reg;
    logic push, pop;
    tick_t cls;

    // fold unused mode codes into plain ticks
    always_comb
    begin
        cls = in_item;
        if (in_item.mode > MODE_WAKE) cls.mode = MODE_TICK;
    end

    assign in_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_item = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (pop) rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

/* rtl/core/i2cm_back.sv */
`default_nettype none
module i2cm_back
    import i2cm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [6:0] dev_addr,
    input  wire logic [7:0] half_ticks,
    input  wire logic [7:0] ack_limit,
    input  wire logic       q_valid,
    output logic            q_ready,
    input  wire tick_t      q_item,
    output logic            out_valid,
    input  wire logic       out_ready,
    output result_t         out_item
);
    localparam logic [3:0] PH_IDLE = 4'd0, PH_START_A = 4'd1, PH_START_B = 4'd2,
        PH_START_C = 4'd3, PH_WLOW = 4'd4, PH_WHIGH = 4'd5, PH_ALOW = 4'd6,
        PH_AHIGH = 4'd7, PH_APOLL = 4'd8, PH_RLOW = 4'd9, PH_RHIGH = 4'd10,
        PH_MLOW = 4'd11, PH_MHIGH = 4'd12, PH_STOP_A = 4'd13, PH_STOP_B = 4'd14,
        PH_STOP_C = 4'd15;
    localparam logic [2:0] SG_ADDRW = 3'd0, SG_REG = 3'd1, SG_DATA = 3'd2,
        SG_ADDRR = 3'd3, SG_READ = 3'd4, SG_WAKE = 3'd5;

    logic [3:0] phase_reg, phase_next, ph;
    logic [2:0] stage_reg, stage_next, stg;
    logic [3:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] half_reg, half_next;
    logic [7:0] poll_reg, poll_next;
    logic [7:0] left_reg, left_next;
    logic [2:0] amode_reg, amode_next;
    logic [7:0] sreg_reg, sreg_next, swd_reg, swd_next;
    logic [1:0] stat_reg, stat_next;
    logic       ov_reg;
    result_t    res_reg, r;
    logic       step;
    logic [7:0] hp;
    logic [8:0] pn;
    logic       seg_end, sda;

    assign q_ready = !ov_reg || out_ready;
    assign step = q_valid && q_ready;
    assign out_valid = ov_reg;
    assign out_item = res_reg;
    assign hp = (half_ticks == 8'd0) ? 8'd1 : half_ticks;
    assign sda = q_item.sda_in;

    always_comb
    begin
        logic [7:0] hc;
        phase_next = phase_reg; stage_next = stage_reg; bit_next = bit_reg;
        shift_next = shift_reg; half_next = half_reg; poll_next = poll_reg;
        left_next = left_reg; amode_next = amode_reg; sreg_next = sreg_reg;
        swd_next = swd_reg; stat_next = stat_reg;
        hc = half_reg;
        pn = {1'b0, poll_reg} + 9'd1;
        r = '0;
        r.scl_level = 1'b1; r.sda_level = 1'b1; r.sda_enable = 1'b1;
        ph = phase_reg;
        stg = stage_reg;
        // accept a command only when idle
        if (phase_reg == PH_IDLE && q_item.mode != MODE_TICK)
        begin
            amode_next = q_item.mode;
            sreg_next = q_item.reg_addr;
            swd_next = q_item.write_data;
            left_next = (q_item.mode == MODE_BURST) ? q_item.read_count : 8'd1;
            stat_next = ST_OK;
            stg = (q_item.mode == MODE_WAKE) ? SG_WAKE : SG_ADDRW;
            stage_next = stg;
            ph = PH_START_A;
            hc = 8'd0;
            phase_next = PH_START_A;
        end
        unique case (ph)
            PH_START_A: r.scl_level = 1'b0;
            PH_START_C: r.sda_level = 1'b0;
            PH_WLOW:  begin r.scl_level = 1'b0; r.sda_level = shift_reg[7]; end
            PH_WHIGH: r.sda_level = shift_reg[7];
            PH_ALOW, PH_RLOW: begin r.scl_level = 1'b0; r.sda_enable = 1'b0; end
            PH_AHIGH, PH_APOLL, PH_RHIGH: r.sda_enable = 1'b0;
            PH_MLOW:  begin r.scl_level = 1'b0; r.sda_level = (left_next <= 8'd1); end
            PH_MHIGH: r.sda_level = (left_next <= 8'd1);
            PH_STOP_A: begin r.scl_level = 1'b0; r.sda_level = 1'b0; end
            PH_STOP_B: r.sda_level = 1'b0;
            default: ;
        endcase
        r.busy_res = (ph != PH_IDLE);
        if (ph == PH_RHIGH && hc == 8'd0) shift_next = {shift_reg[6:0], sda};
        seg_end = ({1'b0, hc} + 9'd1) >= {1'b0, hp};
        if (ph != PH_IDLE && ph != PH_APOLL && !seg_end)
            half_next = hc + 8'd1;
        else
        begin
            half_next = 8'd0;
            unique case (ph)
                PH_START_A: phase_next = PH_START_B;
                PH_START_B: phase_next = PH_START_C;
                PH_START_C:
                begin
                    shift_next = {dev_addr, stg == SG_ADDRR};
                    bit_next = 4'd0; phase_next = PH_WLOW;
                end
                PH_WLOW: phase_next = PH_WHIGH;
                PH_WHIGH:
                begin
                    shift_next = {shift_reg[6:0], 1'b0};
                    bit_next = bit_reg + 4'd1;
                    if (bit_reg + 4'd1 >= 4'd8)
                        phase_next = (stg == SG_WAKE) ? PH_STOP_A : PH_ALOW;
                    else phase_next = PH_WLOW;
                end
                PH_ALOW: phase_next = PH_AHIGH;
                PH_AHIGH: begin poll_next = 8'd0; phase_next = PH_APOLL; end
                PH_APOLL:
                begin
                    logic adv;
                    adv = 1'b0;
                    if (!sda) adv = 1'b1;
                    else if (pn > {1'b0, ack_limit})
                    begin
                        if (stg == SG_ADDRW)
                        begin
                            stat_next = ST_ADDR_NACK; phase_next = PH_STOP_A;
                        end
                        else begin stat_next = ST_LATE_NACK; adv = 1'b1; end
                    end
                    else poll_next = pn[7:0];
                    if (adv)
                    begin
                        priority case (stg)
                            SG_ADDRW:
                            begin
                                stage_next = SG_REG; shift_next = sreg_reg;
                                bit_next = 4'd0; phase_next = PH_WLOW;
                            end
                            SG_REG:
                                if (amode_reg == MODE_WRITE)
                                begin
                                    stage_next = SG_DATA; shift_next = swd_reg;
                                    bit_next = 4'd0; phase_next = PH_WLOW;
                                end
                                else
                                begin
                                    stage_next = SG_ADDRR; phase_next = PH_START_A;
                                end
                            SG_ADDRR:
                                if (left_reg == 8'd0) phase_next = PH_STOP_A;
                                else
                                begin
                                    stage_next = SG_READ; shift_next = 8'd0;
                                    bit_next = 4'd0; phase_next = PH_RLOW;
                                end
                            default: phase_next = PH_STOP_A;
                        endcase
                    end
                end
                PH_RLOW: phase_next = PH_RHIGH;
                PH_RHIGH:
                begin
                    bit_next = bit_reg + 4'd1;
                    if (bit_reg + 4'd1 >= 4'd8)
                    begin
                        r.byte_valid = 1'b1;
                        r.byte_data = shift_next;
                        r.byte_last = (left_reg <= 8'd1);
                        phase_next = PH_MLOW;
                    end
                    else phase_next = PH_RLOW;
                end
                PH_MLOW: phase_next = PH_MHIGH;
                PH_MHIGH:
                begin
                    logic [7:0] nl;
                    nl = (left_reg != 8'd0) ? left_reg - 8'd1 : 8'd0;
                    left_next = nl;
                    if (nl == 8'd0) phase_next = PH_STOP_A;
                    else
                    begin
                        shift_next = 8'd0; bit_next = 4'd0; phase_next = PH_RLOW;
                    end
                end
                PH_STOP_A: phase_next = PH_STOP_B;
                PH_STOP_B: phase_next = PH_STOP_C;
                PH_STOP_C: begin r.done_res = 1'b1; phase_next = PH_IDLE; end
                default: ;
            endcase
        end
        if (!r.sda_enable) r.sda_level = 1'b1;
        r.status = stat_next;
    end

    always_ff @(posedge clk)
    begin
        if (step) res_reg <= r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0; phase_reg <= PH_IDLE; stage_reg <= SG_ADDRW;
            bit_reg <= '0; shift_reg <= '0; half_reg <= '0; poll_reg <= '0;
            left_reg <= '0; amode_reg <= '0; sreg_reg <= '0; swd_reg <= '0;
            stat_reg <= ST_OK;
        end
        else
        begin
            if (step) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
            if (step)
            begin
                phase_reg <= phase_next; stage_reg <= stage_next;
                bit_reg <= bit_next; shift_reg <= shift_next;
                half_reg <= half_next; poll_reg <= poll_next;
                left_reg <= left_next; amode_reg <= amode_next;
                sreg_reg <= sreg_next; swd_reg <= swd_next;
                stat_reg <= stat_next;
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/core/i2c_master_register_access.sv */
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | mode reg_addr write_data read_count sda_in
// out     | output    | out_valid / out_ready | bus lines, flags, read byte, status
// cfg     | input     | cfg_we                | cfg_index, cfg_data
// One tick item per clock while the output is not stalled; each tick yields one
// result item, registered in the result register after it leaves the queue. The bus
// sequencer advances one tick per cycle unless the output stalls, and sets the rate.
// Reset clears the sequencer and queue; config regs return to their defaults. A stalled
// output holds the sequencer, and the two-entry queue absorbs input while it waits.
`default_nettype none
module i2c_master_register_access
    import i2cm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] mode,
    input  wire logic [7:0] reg_addr,
    input  wire logic [7:0] write_data,
    input  wire logic [7:0] read_count,
    input  wire logic       sda_in,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            scl_level,
    output logic            sda_level,
    output logic            sda_enable,
    output logic            busy_res,
    output logic            byte_valid,
    output logic [7:0]      byte_data,
    output logic            byte_last,
    output logic            done_res,
    output logic [1:0]      status,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);
    logic [6:0] dev_reg;
    logic [7:0] half_reg, ack_reg;
    tick_t   in_item, q_item;
    logic    q_valid, q_ready;
    result_t res;

    // hold configuration; a write lands at once, so issue it only while idle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_reg <= DEV_ADDR_RESET;
            half_reg <= HALF_PERIOD_RESET;
            ack_reg <= ACK_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEV:  dev_reg <= cfg_data[6:0];
                CFG_HALF: half_reg <= cfg_data;
                CFG_ACK:  ack_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_item = '{mode: mode, reg_addr: reg_addr, write_data: write_data,
                       read_count: read_count, sda_in: sda_in};

    i2cm_front #(.DEPTH(DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    i2cm_back u_back (
        .clk(clk), .rst_n(rst_n), .dev_addr(dev_reg), .half_ticks(half_reg),
        .ack_limit(ack_reg), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(res)
    );

    assign scl_level = res.scl_level;
    assign sda_level = res.sda_level;
    assign sda_enable = res.sda_enable;
    assign busy_res = res.busy_res;
    assign byte_valid = res.byte_valid;
    assign byte_data = res.byte_data;
    assign byte_last = res.byte_last;
    assign done_res = res.done_res;
    assign status = res.status;
endmodule
`default_nettype wire

/* rtl/core/i2cm_checker.sv */
`default_nettype none
module i2cm_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       sda_enable,
    input wire logic       sda_level,
    input wire logic       byte_valid,
    input wire logic [7:0] byte_data,
    input wire logic       byte_last,
    input wire logic       done_res,
    input wire logic       busy_res,
    input wire logic [1:0] status
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(byte_data))
        else $error("stalled result changed");
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !sda_enable |-> sda_level)
        else $error("released sda not high");
    a_nobyte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> byte_data == 8'd0 && !byte_last)
        else $error("byte fields without valid");
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> busy_res && !byte_valid)
        else $error("done outside a command");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("bad status code");
endmodule

bind i2c_master_register_access i2cm_checker u_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .sda_enable(sda_enable), .sda_level(sda_level), .byte_valid(byte_valid),
    .byte_data(byte_data), .byte_last(byte_last), .done_res(done_res),
    .busy_res(busy_res), .status(status)
);
`default_nettype wire
